/* hw/rtl/tag_presence_table_defines.svh */
// Assertion macros used by the tag presence table datapath.
`ifndef TAG_PRESENCE_TABLE_DEFINES_SVH
`define TAG_PRESENCE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define TPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag presence table: check failed");
// Check cons in the cycle after ante holds.
`define TPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tag presence table: check failed");
`else
`define TPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TPT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/tpt_pkg.sv */
// Types, codes and helper functions of the tag presence table.
`timescale 1ns / 1ps
`default_nettype none
package tpt_pkg;

    localparam int TPT_ENTRIES_DEF = 16;

    // Command codes
    localparam logic [2:0] CMD_FIND   = 3'd0;
    localparam logic [2:0] CMD_COUNT  = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_AGE    = 3'd3;
    localparam logic [2:0] CMD_SET    = 3'd4;

    // Presence states of an entry
    localparam logic [2:0] TAG_NONE      = 3'd0;
    localparam logic [2:0] TAG_NEW       = 3'd1;
    localparam logic [2:0] TAG_REP       = 3'd2;
    localparam logic [2:0] TAG_CONF      = 3'd3;
    localparam logic [2:0] TAG_FADE_REP  = 3'd4;
    localparam logic [2:0] TAG_FADE_CONF = 3'd5;
    localparam logic [2:0] TAG_GONE      = 3'd6;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MISS  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_GRAN   = 1'b0;
    localparam logic CFG_MASTER = 1'b1;

    localparam logic [15:0] GRAN_RESET = 16'd10;

    // Key masks
    localparam logic [31:0] KEY_TOP_BYTE = 32'hff000000;
    localparam logic [31:0] KEY_SEC_BYTE = 32'h00ff0000;
    localparam logic [31:0] KEY_LOW_HALF = 32'h0000ffff;
    localparam logic [31:0] MASK_NO_TOP  = 32'h00ffffff;
    localparam logic [31:0] MASK_ALL     = 32'hffffffff;
    localparam logic [31:0] MASK_NO_SEC  = 32'hff00ffff;
    localparam logic [31:0] MASK_NO_LOW  = 32'hffff0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_AGE_EVAL,
        S_SCAN,
        S_POST,
        S_FINISH
    } t_fsm_state;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INSERT,
        WR_STATE,
        WR_CLEAR
    } t_wr_kind;

    typedef enum logic [1:0] {
        SRC_NST,
        SRC_FADE,
        SRC_GONE
    } t_st_src;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     scan_start;
        logic     scan_free;
        logic     key_from_rd;
        t_wr_kind wr_kind;
        t_st_src  st_src;
        logic     set_gone;
        logic     ld_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       range_err;
        logic       scan_done;
        logic       found;
        logic       dup;
        logic       age_ok;
        logic [2:0] rd_state;
        logic       master;
        logic       out_free;
    } t_dp_stat;

    // Masked key compare: zero key fields are wildcards
    function automatic logic key_match(input logic [31:0] id, input logic [31:0] key);
        logic [31:0] mask;
        logic        ok;
        mask = MASK_ALL;
        ok   = 1'b1;
        if ((key & KEY_TOP_BYTE) == '0) mask = mask & MASK_NO_TOP;
        if ((key & KEY_SEC_BYTE) == '0) mask = mask & MASK_NO_SEC;
        if ((key & KEY_LOW_HALF) == '0) begin
            mask = mask & MASK_NO_LOW;
            if (id == '0) ok = 1'b0;
        end
        return ok && ((id & mask) == key);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/tpt_dp.sv */
// Datapath of the tag presence table: entry memories, scan unit, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "tag_presence_table_defines.svh"
module tpt_dp import tpt_pkg::*; #(
    parameter int TABLE_ENTRIES = TPT_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic [2:0]  i_in_cmd,
    input  wire logic [31:0] i_tag,
    input  wire logic [7:0]  i_index,
    input  wire logic [2:0]  i_new_state,
    input  wire logic [31:0] i_now,
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_entry_index,
    output logic [8:0]       o_match_count,
    output logic             o_report_gone
);

    localparam int         AW          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [8:0] NUM_ENTRIES = 9'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    // Configuration
    logic [15:0] r_gran;
    logic        r_master;

    // Captured request
    logic [2:0]  r_cmd;
    logic [31:0] r_tag;
    logic [7:0]  r_idx;
    logic [2:0]  r_nst;
    logic [31:0] r_now;
    logic        r_gone;

    // Entry storage
    logic [31:0]              r_id_mem   [TABLE_ENTRIES];
    logic [2:0]               r_st_mem   [TABLE_ENTRIES];
    logic [31:0]              r_time_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [31:0] r_rd_id;
    logic [2:0]  r_rd_state;
    logic [31:0] r_rd_time;
    logic        r_rd_vld;
    logic [AW-1:0] r_rd_addr;

    // Scan unit
    logic          r_scan_on;
    logic [AW-1:0] r_addr;
    logic          r_chk;
    logic          r_chk_last;
    logic          r_mode_free;
    logic [31:0]   r_key;
    logic          r_found;
    logic [AW-1:0] r_found_idx;
    logic [8:0]    r_count;

    // Result register
    logic       r_out_valid;
    logic [1:0] r_status;
    logic [7:0] r_eidx;
    logic [8:0] r_cnt;
    logic       r_rgone;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   eff_id;
    logic [2:0]    eff_state;
    logic [31:0]   eff_time;
    logic [31:0]   age;
    logic          range_err;
    logic          hit;
    logic          wr_mem;
    logic          wr_id;
    logic [31:0]   wr_id_data;
    logic [2:0]    wr_st_data;
    logic          out_free;
    logic [1:0]    n_status;
    logic [7:0]    n_eidx;
    logic [8:0]    n_cnt;
    logic          n_rgone;

    // Mask entries that were never written or have been cleared
    assign eff_id    = r_rd_vld ? r_rd_id : '0;
    assign eff_state = r_rd_vld ? r_rd_state : TAG_NONE;
    assign eff_time  = r_rd_vld ? r_rd_time : '0;
    assign age       = r_now - eff_time;
    assign range_err = {1'b0, r_idx} >= NUM_ENTRIES;
    assign hit       = r_mode_free ? (eff_id == '0) : key_match(eff_id, r_key);
    assign out_free  = !r_out_valid || i_out_ready;

    assign rd_addr = r_scan_on ? r_addr : r_idx[AW-1:0];
    assign wr_addr = (i_cmd.wr_kind == WR_INSERT) ? r_found_idx : r_idx[AW-1:0];

    // Select write data
    always_comb begin
        wr_mem     = (i_cmd.wr_kind == WR_INSERT) || (i_cmd.wr_kind == WR_STATE);
        wr_id      = (i_cmd.wr_kind == WR_INSERT) ||
                     ((i_cmd.wr_kind == WR_STATE) && !r_valid[wr_addr]);
        wr_id_data = (i_cmd.wr_kind == WR_INSERT) ? r_tag : '0;
        if (i_cmd.wr_kind == WR_INSERT) begin
            wr_st_data = TAG_NEW;
        end else begin
            case (i_cmd.st_src)
                SRC_NST:  wr_st_data = r_nst;
                SRC_FADE: wr_st_data = (eff_state == TAG_REP) ? TAG_FADE_REP : TAG_FADE_CONF;
                SRC_GONE: wr_st_data = TAG_GONE;
                default:  wr_st_data = r_nst;
            endcase
        end
    end

    // Write and read the entry memories
    always_ff @(posedge i_clk) begin
        if (wr_id) begin
            r_id_mem[wr_addr] <= wr_id_data;
        end
        if (wr_mem) begin
            r_st_mem[wr_addr]   <= wr_st_data;
            r_time_mem[wr_addr] <= r_now;
        end
        r_rd_id    <= r_id_mem[rd_addr];
        r_rd_state <= r_st_mem[rd_addr];
        r_rd_time  <= r_time_mem[rd_addr];
        r_rd_addr  <= rd_addr;
    end

    // Track which entries hold data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_mem) begin
                r_valid[wr_addr] <= 1'b1;
            end else if (i_cmd.wr_kind == WR_CLEAR) begin
                r_valid[wr_addr] <= 1'b0;
            end
            r_rd_vld <= r_valid[rd_addr];
        end
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gran   <= GRAN_RESET;
            r_master <= 1'b1;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_GRAN:   r_gran   <= i_cfg_wdata;
                CFG_MASTER: r_master <= i_cfg_wdata[0];
                default:    r_gran   <= r_gran;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_in_cmd;
            r_tag <= i_tag;
            r_idx <= i_index;
            r_nst <= i_new_state;
            r_now <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gone <= 1'b0;
        end else if (i_cmd.capture) begin
            r_gone <= 1'b0;
        end else if (i_cmd.set_gone) begin
            r_gone <= 1'b1;
        end
    end

    // Walk the table one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on   <= 1'b0;
            r_addr      <= '0;
            r_chk       <= 1'b0;
            r_chk_last  <= 1'b0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_count     <= '0;
        end else begin
            r_chk      <= r_scan_on;
            r_chk_last <= r_scan_on && (r_addr == LAST_ADDR);
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_addr    <= '0;
                r_found   <= 1'b0;
                r_count   <= '0;
            end else begin
                if (r_scan_on) begin
                    r_scan_on <= (r_addr != LAST_ADDR);
                    r_addr    <= r_addr + 1'b1;
                end
                if (r_chk && hit) begin
                    r_count <= r_count + 1'b1;
                    if (!r_found) begin
                        r_found     <= 1'b1;
                        r_found_idx <= r_rd_addr;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_mode_free <= i_cmd.scan_free;
            r_key       <= i_cmd.key_from_rd ? (eff_id & MASK_NO_TOP) : r_tag;
        end
    end

    // Form the result fields
    always_comb begin
        n_status = STAT_OK;
        n_eidx   = '0;
        n_cnt    = '0;
        n_rgone  = 1'b0;
        case (r_cmd)
            CMD_FIND, CMD_INSERT: begin
                n_status = r_found ? STAT_OK : STAT_MISS;
                n_eidx   = r_found ? 8'(r_found_idx) : '0;
            end
            CMD_COUNT: begin
                n_cnt = r_count;
            end
            CMD_AGE, CMD_SET: begin
                if (range_err) begin
                    n_status = STAT_RANGE;
                end else begin
                    n_eidx  = r_idx;
                    n_rgone = r_gone;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_status <= n_status;
            r_eidx   <= n_eidx;
            r_cnt    <= n_cnt;
            r_rgone  <= n_rgone;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_index = r_eidx;
    assign o_match_count = r_cnt;
    assign o_report_gone = r_rgone;

    // Report status to the controller
    always_comb begin
        o_stat           = '0;
        o_stat.cmd       = r_cmd;
        o_stat.range_err = range_err;
        o_stat.scan_done = r_chk_last;
        o_stat.found     = r_found;
        o_stat.dup       = r_count > 9'd1;
        o_stat.age_ok    = (eff_id != '0) && (age >= {16'b0, r_gran});
        o_stat.rd_state  = eff_state;
        o_stat.master    = r_master;
        o_stat.out_free  = out_free;
    end

    `TPT_ASSERT_IMP(a_no_write_in_scan, i_clk, i_rst_n, r_scan_on, i_cmd.wr_kind == WR_NONE)
    `TPT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_chk, r_count <= NUM_ENTRIES)
    `TPT_ASSERT_NXT(a_scan_ends, i_clk, i_rst_n, r_chk_last, !r_chk && !r_scan_on)

endmodule
`default_nettype wire

/* hw/rtl/tpt_ctrl.sv */
// Controller state machine of the tag presence table.
`timescale 1ns / 1ps
`default_nettype none
module tpt_ctrl import tpt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_fsm_state r_state;
    t_fsm_state n_state;
    logic       is_fading;

    assign is_fading = (i_stat.rd_state == TAG_FADE_REP) ||
                       (i_stat.rd_state == TAG_FADE_CONF);

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_FIND, CMD_COUNT, CMD_INSERT: n_state = S_SCAN;
                    CMD_AGE: n_state = i_stat.range_err ? S_FINISH : S_AGE_EVAL;
                    default: n_state = S_FINISH;
                endcase
            end
            S_AGE_EVAL: begin
                n_state = (i_stat.age_ok && is_fading) ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_POST;
            end
            S_POST: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.wr_kind = WR_NONE;
        o_cmd.st_src  = SRC_NST;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_FIND, CMD_COUNT: begin
                        o_cmd.scan_start = 1'b1;
                    end
                    CMD_INSERT: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_free  = 1'b1;
                    end
                    CMD_SET: begin
                        if (!i_stat.range_err) begin
                            o_cmd.wr_kind = WR_STATE;
                            o_cmd.st_src  = SRC_NST;
                        end
                    end
                    default: begin
                        o_cmd.scan_start = 1'b0;
                    end
                endcase
            end
            S_AGE_EVAL: begin
                if (i_stat.age_ok) begin
                    case (i_stat.rd_state)
                        TAG_NEW: begin
                            o_cmd.wr_kind = WR_CLEAR;
                        end
                        TAG_GONE: begin
                            o_cmd.set_gone = 1'b1;
                        end
                        TAG_REP, TAG_CONF: begin
                            o_cmd.wr_kind = WR_STATE;
                            o_cmd.st_src  = SRC_FADE;
                        end
                        TAG_FADE_REP, TAG_FADE_CONF: begin
                            // count entries sharing the low three bytes
                            o_cmd.scan_start  = 1'b1;
                            o_cmd.key_from_rd = 1'b1;
                        end
                        default: begin
                            o_cmd.wr_kind = WR_NONE;
                        end
                    endcase
                end
            end
            S_POST: begin
                if (i_stat.cmd == CMD_INSERT) begin
                    if (i_stat.found) o_cmd.wr_kind = WR_INSERT;
                end else if (i_stat.cmd == CMD_AGE) begin
                    if (i_stat.dup) begin
                        // drop a duplicate silently
                        o_cmd.wr_kind = WR_CLEAR;
                    end else begin
                        o_cmd.set_gone = 1'b1;
                        o_cmd.wr_kind  = i_stat.master ? WR_CLEAR : WR_STATE;
                        o_cmd.st_src   = SRC_GONE;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.ld_out = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/tag_presence_table.sv */
// Tag presence table: one request at a time, entries scanned one per cycle.
// Find, count and insert scan the whole table; age scans it only when an aged entry is fading;
// set state and unknown commands do not scan. The next request is accepted once the result
// has been loaded into the output register, which waits until the previous result is taken.
// The single read port of the entry memories sets the scan length.
// Synchronous active-low reset empties the table at once and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module tag_presence_table import tpt_pkg::*; #(
    parameter int TABLE_ENTRIES = TPT_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_tag,
    input  wire logic [7:0]  i_index,
    input  wire logic [2:0]  i_new_state,
    input  wire logic [31:0] i_now,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_entry_index,
    output logic [8:0]       o_match_count,
    output logic             o_report_gone,
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each request
    tpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Store entries, scan and hold the result
    tpt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_in_cmd      (i_cmd),
        .i_tag         (i_tag),
        .i_index       (i_index),
        .i_new_state   (i_new_state),
        .i_now         (i_now),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_match_count (o_match_count),
        .o_report_gone (o_report_gone)
    );

endmodule
`default_nettype wire
